FILE: rtl/ers_pkg.sv
// ers_pkg: shared constants, codes, types and ring pointer helpers
// for the edge-resynchronized bit sampler. No dependencies.
package ers_pkg;

  localparam int unsigned RING_DEPTH = 8192;
  localparam int unsigned PTR_SPAN   = 2 * RING_DEPTH;
  localparam int unsigned PTR_W      = $clog2(PTR_SPAN);
  localparam int unsigned ADDR_W     = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W     = PTR_W + 1;

  localparam int unsigned STEP_W  = 10;
  localparam int unsigned SINCE_W = 11;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SUM_W   = 48;

  localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
  localparam logic [STEP_W-1:0]  STEP_MIN  = STEP_W'(5);
  localparam logic [STEP_W-1:0]  STEP_MAX  = STEP_W'(1000);
  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(100);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_JIT_LOW   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_JIT_HIGH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_JIT_EN    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE      = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_EN   = CFG_IDX_W'(5);

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_STOP  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REASON_NONE     = 2'd0,
    REASON_IDLE     = 2'd1,
    REASON_OVERFLOW = 2'd2,
    REASON_STOP     = 2'd3
  } reason_e;

  typedef struct packed {
    logic             is_running;
    logic [1:0]       stop_reason;
    logic [CNT_W-1:0] bytes_total;
    logic [CNT_W-1:0] samples_total;
    logic [CNT_W-1:0] edges_total;
    logic [CNT_W-1:0] edges_dropped;
    logic [SUM_W-1:0] offset_sum_even;
    logic [SUM_W-1:0] offset_sum_odd;
  } ers_stat_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    ers_stat_t  stat;
  } ers_out_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(PTR_SPAN - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_index(input logic [PTR_W-1:0] p);
    return (p >= PTR_W'(RING_DEPTH)) ? ADDR_W'(p - PTR_W'(RING_DEPTH)) : ADDR_W'(p);
  endfunction

endpackage

FILE: rtl/ers_in_if.sv
// ers_in_if: request channel into the sampler (func, data and busy pins).
// Depends on ers_pkg.
interface ers_in_if import ers_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       data_level;
  logic       busy_level;

  modport source (output valid, func, data_level, busy_level, input ready);
  modport sink   (input valid, func, data_level, busy_level, output ready);
endinterface

FILE: rtl/ers_out_if.sv
// ers_out_if: result channel out of the sampler, one result per request.
// Depends on ers_pkg.
interface ers_out_if import ers_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       byte_out;
  logic             byte_valid;
  logic             is_running;
  logic [1:0]       stop_reason;
  logic [CNT_W-1:0] bytes_total;
  logic [CNT_W-1:0] samples_total;
  logic [CNT_W-1:0] edges_total;
  logic [CNT_W-1:0] edges_dropped;
  logic [SUM_W-1:0] offset_sum_even;
  logic [SUM_W-1:0] offset_sum_odd;

  modport source (output valid, byte_out, byte_valid, is_running, stop_reason, bytes_total,
                  samples_total, edges_total, edges_dropped, offset_sum_even,
                  offset_sum_odd, input ready);
  modport sink   (input valid, byte_out, byte_valid, is_running, stop_reason, bytes_total,
                  samples_total, edges_total, edges_dropped, offset_sum_even,
                  offset_sum_odd, output ready);
endinterface

FILE: rtl/ers_cfg_if.sv
// ers_cfg_if: configuration write channel (register index and data).
// Depends on ers_pkg.
interface ers_cfg_if import ers_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ers_ram.sv
// ers_ram: generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ers_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ers_core.sv
// ers_core: configuration registers, run state, sampling and edge tracking,
// and ring pointer control. Drives the ring RAM ports. Depends on ers_pkg, ers_in_if,
// ers_cfg_if.
module ers_core import ers_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ers_in_if.sink            in_ch,
  ers_cfg_if.sink           cfg_ch,
  input  logic              space_i,
  output logic              acc_o,
  output logic              byte_vld_o,
  output ers_stat_t         stat_o,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  output logic              ram_re_o,
  output logic [ADDR_W-1:0] ram_raddr_o
);

  // programmed registers
  logic [STEP_W-1:0]     cfg_step_q, cfg_jit_lo_q, cfg_jit_hi_q;
  logic [1:0]            cfg_jen_q;
  logic [CNT_W-1:0]      cfg_idle_q;
  logic                  cfg_busy_q;

  // per-run copies
  logic [STEP_W-1:0]     run_step_q, run_step_d, run_jit_lo_q, run_jit_lo_d;
  logic [STEP_W-1:0]     run_jit_hi_q, run_jit_hi_d;
  logic [1:0]            run_jen_q, run_jen_d;
  logic [CNT_W-1:0]      run_idle_q, run_idle_d;
  logic                  run_busy_q, run_busy_d;

  logic [PTR_W-1:0]      wp_q, wp_d, rp_q, rp_d;
  logic [7:0]            shift_q, shift_d, shift_new;
  logic [2:0]            bits_q, bits_d;
  logic [CNT_W-1:0]      idle_q, idle_d;
  logic                  parity_q, parity_d, eip_q, eip_d, active_q, active_d;
  logic [1:0]            reason_q, reason_d;
  logic [SINCE_W-1:0]    since_q, since_d, since_inc;
  logic [STEP_W-1:0]     until_q, until_d, until_dec, jit_sel, resync;
  logic                  prev_q, prev_d;
  logic [CNT_W-1:0]      bytes_q, bytes_d, samples_q, samples_d;
  logic [CNT_W-1:0]      edges_q, edges_d, dropped_q, dropped_d;
  logic [SUM_W-1:0]      sum_even_q, sum_even_d, sum_odd_q, sum_odd_d;

  logic                  acc, tick_edge, step_ok, idle_stop, post_ok;
  logic [FILL_W-1:0]     fill;
  logic                  cfg_acc;

  assign in_ch.ready  = space_i;
  assign cfg_ch.ready = 1'b1;
  assign acc          = in_ch.valid && space_i;
  assign cfg_acc      = cfg_ch.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_step_q   <= STEP_RST;
      cfg_jit_lo_q <= '0;
      cfg_jit_hi_q <= '0;
      cfg_jen_q    <= '0;
      cfg_idle_q   <= '0;
      cfg_busy_q   <= 1'b0;
    end else if (cfg_acc) begin
      case (cfg_ch.index)
        CFG_STEP:     cfg_step_q   <= cfg_ch.data[STEP_W-1:0];
        CFG_JIT_LOW:  cfg_jit_lo_q <= cfg_ch.data[STEP_W-1:0];
        CFG_JIT_HIGH: cfg_jit_hi_q <= cfg_ch.data[STEP_W-1:0];
        CFG_JIT_EN:   cfg_jen_q    <= cfg_ch.data[1:0];
        CFG_IDLE:     cfg_idle_q   <= cfg_ch.data[CNT_W-1:0];
        CFG_BUSY_EN:  cfg_busy_q   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign tick_edge = in_ch.data_level != prev_q;
  assign since_inc = (since_q < SINCE_MAX) ? since_q + 1'b1 : since_q;
  assign until_dec = (until_q != '0) ? until_q - 1'b1 : '0;
  assign jit_sel   = parity_q ? run_jit_hi_q : run_jit_lo_q;
  assign resync    = (run_step_q > jit_sel) ? run_step_q - jit_sel : '0;
  assign step_ok   = (cfg_step_q >= STEP_MIN) && (cfg_step_q <= STEP_MAX);
  assign fill      = (wp_q >= rp_q) ? FILL_W'(wp_q) - FILL_W'(rp_q)
                                    : FILL_W'(wp_q) + FILL_W'(PTR_SPAN) - FILL_W'(rp_q);
  assign shift_new = {shift_q[6:0], in_ch.data_level};

  always_comb begin
    run_step_d   = run_step_q;
    run_jit_lo_d = run_jit_lo_q;
    run_jit_hi_d = run_jit_hi_q;
    run_jen_d    = run_jen_q;
    run_idle_d   = run_idle_q;
    run_busy_d   = run_busy_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    shift_d      = shift_q;
    bits_d       = bits_q;
    idle_d       = idle_q;
    parity_d     = parity_q;
    eip_d        = eip_q;
    active_d     = active_q;
    reason_d     = reason_q;
    since_d      = since_q;
    until_d      = until_q;
    prev_d       = prev_q;
    bytes_d      = bytes_q;
    samples_d    = samples_q;
    edges_d      = edges_q;
    dropped_d    = dropped_q;
    sum_even_d   = sum_even_q;
    sum_odd_d    = sum_odd_q;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    byte_vld_o   = 1'b0;
    idle_stop    = 1'b0;
    post_ok      = 1'b0;
    if (acc) begin
      case (func_e'(in_ch.func))
        FUNC_START: begin
          if (!active_q && step_ok) begin
            run_step_d   = cfg_step_q;
            run_jit_lo_d = cfg_jit_lo_q;
            run_jit_hi_d = cfg_jit_hi_q;
            run_jen_d    = cfg_jen_q;
            run_idle_d   = cfg_idle_q;
            run_busy_d   = cfg_busy_q;
            wp_d         = '0;
            rp_d         = '0;
            shift_d      = '0;
            bits_d       = '0;
            idle_d       = cfg_idle_q;
            parity_d     = 1'b0;
            eip_d        = 1'b0;
            reason_d     = REASON_NONE;
            bytes_d      = '0;
            samples_d    = '0;
            edges_d      = '0;
            dropped_d    = '0;
            sum_even_d   = '0;
            sum_odd_d    = '0;
            since_d      = '0;
            until_d      = cfg_step_q;
            prev_d       = in_ch.data_level;
            active_d     = 1'b1;
          end
        end
        FUNC_TICK: begin
          prev_d = in_ch.data_level;
          if (active_q) begin
            since_d = since_inc;
            until_d = until_dec;
            if (tick_edge) begin
              if (since_inc > SINCE_W'(run_step_q)) begin
                dropped_d = dropped_q + 1'b1;
              end else begin
                if (parity_q) begin
                  sum_odd_d = sum_odd_q + SUM_W'(since_inc);
                end else begin
                  sum_even_d = sum_even_q + SUM_W'(since_inc);
                end
                if (run_jen_q[parity_q]) begin
                  until_d = resync;
                end
                parity_d = !parity_q;
                edges_d  = edges_q + 1'b1;
                eip_d    = 1'b1;
              end
            end
            if (until_d == '0) begin
              if (eip_d) begin
                eip_d  = 1'b0;
                idle_d = run_idle_q;
              end else if (run_idle_q != '0) begin
                idle_d    = idle_q - 1'b1;
                idle_stop = (idle_d == '0);
              end
              if (idle_stop) begin
                active_d = 1'b0;
                reason_d = REASON_IDLE;
              end else begin
                since_d   = '0;
                samples_d = samples_q + 1'b1;
                if (bits_q == 3'd7) begin
                  bits_d  = '0;
                  shift_d = '0;
                  if (fill >= FILL_W'(RING_DEPTH)) begin
                    active_d = 1'b0;
                    reason_d = REASON_OVERFLOW;
                  end else begin
                    ram_we_o = 1'b1;
                    wp_d     = ptr_next(wp_q);
                    bytes_d  = bytes_q + 1'b1;
                    post_ok  = 1'b1;
                  end
                end else begin
                  bits_d  = bits_q + 1'b1;
                  shift_d = shift_new;
                  post_ok = 1'b1;
                end
                if (post_ok) begin
                  if (run_busy_q && in_ch.busy_level) begin
                    active_d = 1'b0;
                    reason_d = REASON_STOP;
                  end else begin
                    until_d = run_step_q;
                  end
                end
              end
            end
          end
        end
        FUNC_READ: begin
          if (fill != '0) begin
            ram_re_o   = 1'b1;
            rp_d       = ptr_next(rp_q);
            byte_vld_o = 1'b1;
          end
        end
        FUNC_STOP: begin
          active_d = 1'b0;
          if (reason_q == REASON_NONE) begin
            reason_d = REASON_STOP;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_step_q   <= STEP_RST;
      run_jit_lo_q <= '0;
      run_jit_hi_q <= '0;
      run_jen_q    <= '0;
      run_idle_q   <= '0;
      run_busy_q   <= 1'b0;
      wp_q         <= '0;
      rp_q         <= '0;
      shift_q      <= '0;
      bits_q       <= '0;
      idle_q       <= '0;
      parity_q     <= 1'b0;
      eip_q        <= 1'b0;
      active_q     <= 1'b0;
      reason_q     <= REASON_NONE;
      since_q      <= '0;
      until_q      <= '0;
      prev_q       <= 1'b0;
      bytes_q      <= '0;
      samples_q    <= '0;
      edges_q      <= '0;
      dropped_q    <= '0;
      sum_even_q   <= '0;
      sum_odd_q    <= '0;
    end else begin
      run_step_q   <= run_step_d;
      run_jit_lo_q <= run_jit_lo_d;
      run_jit_hi_q <= run_jit_hi_d;
      run_jen_q    <= run_jen_d;
      run_idle_q   <= run_idle_d;
      run_busy_q   <= run_busy_d;
      wp_q         <= wp_d;
      rp_q         <= rp_d;
      shift_q      <= shift_d;
      bits_q       <= bits_d;
      idle_q       <= idle_d;
      parity_q     <= parity_d;
      eip_q        <= eip_d;
      active_q     <= active_d;
      reason_q     <= reason_d;
      since_q      <= since_d;
      until_q      <= until_d;
      prev_q       <= prev_d;
      bytes_q      <= bytes_d;
      samples_q    <= samples_d;
      edges_q      <= edges_d;
      dropped_q    <= dropped_d;
      sum_even_q   <= sum_even_d;
      sum_odd_q    <= sum_odd_d;
    end
  end

  assign acc_o       = acc;
  assign ram_waddr_o = ptr_index(wp_q);
  assign ram_wdata_o = shift_new;
  assign ram_raddr_o = ptr_index(rp_q);

  assign stat_o.is_running      = active_q;
  assign stat_o.stop_reason     = reason_q;
  assign stat_o.bytes_total     = bytes_q;
  assign stat_o.samples_total   = samples_q;
  assign stat_o.edges_total     = edges_q;
  assign stat_o.edges_dropped   = dropped_q;
  assign stat_o.offset_sum_even = sum_even_q;
  assign stat_o.offset_sum_odd  = sum_odd_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= FILL_W'(RING_DEPTH))
    else $error("ring fill above depth");

  a_write_when_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (active_q && acc))
    else $error("ring write outside a run");

  a_start_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_ch.func == FUNC_START && active_q) |=> (active_q && $stable(wp_q)))
    else $error("start disturbed a running run");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("ring read and write in one request");

endmodule

FILE: rtl/ers_outq.sv
// ers_outq: ring read-latency stage and result queue toward the output channel.
// Depends on ers_pkg and ers_out_if.
module ers_outq import ers_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic       byte_vld_i,
  input  ers_stat_t  stat_i,
  input  logic [7:0] ram_rdata_i,
  output logic       space_o,
  ers_out_if.source  out_ch
);

  ers_out_t              q_mem [OQ_DEPTH];
  logic                  s1_valid_q, s1_bv_q;
  logic [OQ_PTR_W-1:0]   wp_q, rp_q;
  logic [OQ_CNT_W-1:0]   cnt_q, cnt_d, occ;
  logic                  pop;
  ers_out_t              entry;

  assign occ     = cnt_q + OQ_CNT_W'(s1_valid_q);
  assign space_o = occ < OQ_CNT_W'(OQ_DEPTH);
  assign pop     = out_ch.valid && out_ch.ready;

  // state after a request is in the core registers in the cycle after accept, with its read stage
  assign entry.byte_out   = s1_bv_q ? ram_rdata_i : 8'd0;
  assign entry.byte_valid = s1_bv_q;
  assign entry.stat       = stat_i;

  always_comb begin
    cnt_d = cnt_q;
    if (s1_valid_q && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!s1_valid_q && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_bv_q    <= 1'b0;
      wp_q       <= '0;
      rp_q       <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= acc_i;
      s1_bv_q    <= acc_i && byte_vld_i;
      cnt_q      <= cnt_d;
      if (s1_valid_q) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      q_mem[wp_q] <= entry;
    end
  end

  assign out_ch.valid           = cnt_q != '0;
  assign out_ch.byte_out        = q_mem[rp_q].byte_out;
  assign out_ch.byte_valid      = q_mem[rp_q].byte_valid;
  assign out_ch.is_running      = q_mem[rp_q].stat.is_running;
  assign out_ch.stop_reason     = q_mem[rp_q].stat.stop_reason;
  assign out_ch.bytes_total     = q_mem[rp_q].stat.bytes_total;
  assign out_ch.samples_total   = q_mem[rp_q].stat.samples_total;
  assign out_ch.edges_total     = q_mem[rp_q].stat.edges_total;
  assign out_ch.edges_dropped   = q_mem[rp_q].stat.edges_dropped;
  assign out_ch.offset_sum_even = q_mem[rp_q].stat.offset_sum_even;
  assign out_ch.offset_sum_odd  = q_mem[rp_q].stat.offset_sum_odd;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue count above depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (cnt_q < OQ_CNT_W'(OQ_DEPTH)))
    else $error("push into full result queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OQ_PTR_W'(wp_q - rp_q) == OQ_PTR_W'(cnt_q))
    else $error("queue pointers disagree with count");

endmodule

FILE: rtl/edge_resync_bit_sampler_top.sv
// edge_resync_bit_sampler_top: top level of the edge-resynchronized bit sampler.
// Depends on ers_pkg, ers_in_if, ers_out_if, ers_cfg_if, ers_ram, ers_core, ers_outq.
//
// Usage: each request on in_ch is start, one-microsecond tick (with data and
// busy pin levels), read one byte, or stop. Every request gives exactly one
// result on out_ch, in order: the byte read (if any) and the run status,
// counters and offset sums as they stand after that request.
// cfg_ch writes the six run registers; it is always ready, and a start
// request latches them for the run. Write only while no request is pending.
// A result passes through the core update and ring RAM read, then into the
// result queue, before it is offered on out_ch.
// Throughput: one request per cycle while in_ch is ready; every request updates the state
// once, and the 8192-byte ring RAM takes one write or one read each.
// A four-entry result queue holds results while out_ch is stalled; in_ch
// stays ready until the queued results plus the one in the read stage fill it.
// Reset clears the run state, counters, queue and registers to their
// defaults; ring contents are not cleared, since a run restarts the pointers.
module edge_resync_bit_sampler_top import ers_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ers_in_if.sink     in_ch,
  ers_out_if.source  out_ch,
  ers_cfg_if.sink    cfg_ch
);

  logic              space, acc, byte_vld;
  ers_stat_t         stat;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  ers_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cfg_ch      (cfg_ch),
    .space_i     (space),
    .acc_o       (acc),
    .byte_vld_o  (byte_vld),
    .stat_o      (stat),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  ers_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ers_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .byte_vld_i  (byte_vld),
    .stat_i      (stat),
    .ram_rdata_i (ram_rdata),
    .space_o     (space),
    .out_ch      (out_ch)
  );

endmodule
